// File: hw/rtl/tftp_rx_pkg.sv
// tftp_rx_pkg: shared types and constants of the tftp read-transfer receiver
// event codes, action and status codes, transfer stages, stream field widths
// no dependencies

package tftp_rx_pkg;

  // payload size of a full data block, shorter payload marks the last block
  localparam int unsigned BLOCK_BYTES = 512;

  localparam int unsigned TidW      = 48;
  localparam int unsigned WordW     = 16;
  localparam int unsigned LenW      = 10;
  localparam int unsigned RetryW    = 8;
  localparam int unsigned InDataW   = 128;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned CodeW     = 3;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [RetryW-1:0] MaxRetriesRst = 8'd3;
  localparam logic [WordW-1:0]  OpcData       = 16'd3;
  localparam logic [ApbAddrW-1:0] RegMaxRetries = 3'd0;

  typedef enum logic [CodeW-1:0] {
    OP_START   = 3'd0,
    OP_TIMEOUT = 3'd1,
    OP_FRAME   = 3'd2,
    OP_SENT    = 3'd3,
    OP_SEND_ERR = 3'd4,
    OP_ABORT   = 3'd5
  } op_e;

  typedef enum logic [CodeW-1:0] {
    ACT_NONE    = 3'd0,
    ACT_REQUEST = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_RECEIVE = 3'd3,
    ACT_FINISH  = 3'd4
  } act_e;

  typedef enum logic [CodeW-1:0] {
    STS_RUNNING    = 3'd0,
    STS_SUCCESS    = 3'd1,
    STS_TIMEOUT    = 3'd2,
    STS_BAD_SERVER = 3'd3,
    STS_REMOTE_ERR = 3'd4,
    STS_SINK_ERR   = 3'd5,
    STS_SEND_ERR   = 3'd6,
    STS_USER_ABORT = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    STG_CONSTRUCTED = 4'b0001,
    STG_RUNNING     = 4'b0010,
    STG_ABORTED     = 4'b0100,
    STG_COMPLETED   = 4'b1000
  } stage_e;

  typedef struct packed {
    logic [WordW-1:0] link_error;
    logic             sink_ok;
    logic [LenW-1:0]  data_len;
    logic [WordW-1:0] remote_error;
    logic [WordW-1:0] blk_num;
    logic [WordW-1:0] opcode;
    logic             frame_ok;
    logic [TidW-1:0]  src_tid;
  } event_t;

  typedef struct packed {
    logic [WordW-1:0] status_detail;
    status_e          status;
    logic             store_data;
    logic [WordW-1:0] ack_block;
  } result_t;

endpackage

// File: hw/rtl/tftp_read_transfer_receiver_top.sv
// tftp_read_transfer_receiver_top: download side of a tftp transfer
// takes one event beat, returns one action beat; uses tftp_rx_pkg
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tuser op, tdata event fields
//  m_axis    out  tvalid/tready             tuser action, tdata result fields
//  apb       in   psel/penable/pwrite/pready  max_retries at byte address 0
//
// one event beat per cycle while result beats are taken; from accept to result
// beat an event passes an input register, then the transfer state logic writing the result register
// rst_ni clears the transfer state and sets max_retries to 3
// a stalled result holds in the result register; one more event waits in the
// input register, then s_axis_tready drops until the result beat is taken

module tftp_read_transfer_receiver_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // event beat
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // src_tid, frame_ok, opcode, block number, remote_error, data_len, sink_ok,
  // link_error, 4 unused bits
  input  logic [tftp_rx_pkg::InDataW-1:0]   s_axis_tdata,
  // op
  input  logic [tftp_rx_pkg::CodeW-1:0]     s_axis_tuser,
  // action beat
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // ack_block, store_data, status, status_detail, 4 zero bits
  output logic [tftp_rx_pkg::OutDataW-1:0]  m_axis_tdata,
  // action
  output logic [tftp_rx_pkg::CodeW-1:0]     m_axis_tuser,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tftp_rx_pkg::ApbAddrW-1:0]  paddr,
  input  logic [tftp_rx_pkg::ApbDataW-1:0]  pwdata,
  output logic [tftp_rx_pkg::ApbDataW-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned EvW  = $bits(tftp_rx_pkg::event_t);
  localparam int unsigned ResW = $bits(tftp_rx_pkg::result_t);

  // configuration register
  logic [tftp_rx_pkg::RetryW-1:0] max_retries_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[tftp_rx_pkg::ApbAddrW-1:2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q <= tftp_rx_pkg::MaxRetriesRst;
    end else if (cfg_wr) begin
      max_retries_q <= pwdata[tftp_rx_pkg::RetryW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[tftp_rx_pkg::ApbAddrW-1:2] == 1'b0) begin
      prdata = {{(tftp_rx_pkg::ApbDataW - tftp_rx_pkg::RetryW){1'b0}}, max_retries_q};
    end
  end

  // pipeline handshake
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_take;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input register, payload only
  tftp_rx_pkg::event_t ev_q;
  tftp_rx_pkg::op_e    op_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ev_q <= tftp_rx_pkg::event_t'(s_axis_tdata[EvW-1:0]);
      op_q <= tftp_rx_pkg::op_e'(s_axis_tuser);
    end
  end

  // transfer state
  tftp_rx_pkg::stage_e             stage_q, stage_d;
  logic [tftp_rx_pkg::WordW-1:0]   last_blk_q, last_blk_d;
  logic [tftp_rx_pkg::RetryW-1:0]  retries_q, retries_d;
  logic [tftp_rx_pkg::TidW-1:0]    server_q, server_d;
  logic                            server_known_q, server_known_d;
  logic                            final_q, final_d;

  // result of the current event
  tftp_rx_pkg::act_e    act_d;
  tftp_rx_pkg::result_t res_d;

  logic                           live;
  logic                           retry_gone;
  logic [tftp_rx_pkg::RetryW-1:0] retries_inc;
  logic [tftp_rx_pkg::WordW-1:0]  next_blk;
  logic                           short_blk;

  assign live        = (stage_q == tftp_rx_pkg::STG_RUNNING) |
                       (stage_q == tftp_rx_pkg::STG_ABORTED);
  // budget check happens before the count goes up, count saturates
  assign retry_gone  = retries_q >= max_retries_q;
  assign retries_inc = (retries_q == '1) ? retries_q : retries_q + 1'b1;
  assign next_blk    = last_blk_q + 1'b1;
  assign short_blk   = {{(tftp_rx_pkg::WordW - tftp_rx_pkg::LenW){1'b0}}, ev_q.data_len}
                       != tftp_rx_pkg::WordW'(tftp_rx_pkg::BLOCK_BYTES);

  always_comb begin
    stage_d        = stage_q;
    last_blk_d     = last_blk_q;
    retries_d      = retries_q;
    server_d       = server_q;
    server_known_d = server_known_q;
    final_d        = final_q;
    act_d          = tftp_rx_pkg::ACT_NONE;
    res_d          = '0;

    unique case (op_q)
      tftp_rx_pkg::OP_START: begin
        if (stage_q == tftp_rx_pkg::STG_CONSTRUCTED) begin
          stage_d = tftp_rx_pkg::STG_RUNNING;
          act_d   = tftp_rx_pkg::ACT_REQUEST;
        end
      end
      tftp_rx_pkg::OP_TIMEOUT: begin
        if (stage_q == tftp_rx_pkg::STG_ABORTED) begin
          stage_d    = tftp_rx_pkg::STG_COMPLETED;
          act_d      = tftp_rx_pkg::ACT_FINISH;
          res_d.status = tftp_rx_pkg::STS_USER_ABORT;
        end else if (live) begin
          retries_d = retries_inc;
          if (retry_gone) begin
            stage_d      = tftp_rx_pkg::STG_COMPLETED;
            act_d        = tftp_rx_pkg::ACT_FINISH;
            res_d.status = tftp_rx_pkg::STS_TIMEOUT;
          end else if (last_blk_q == '0) begin
            // nothing received yet, repeat the read request
            act_d = tftp_rx_pkg::ACT_REQUEST;
          end else begin
            act_d           = tftp_rx_pkg::ACT_ACK;
            res_d.ack_block = last_blk_q;
          end
        end
      end
      tftp_rx_pkg::OP_FRAME: begin
        if (stage_q == tftp_rx_pkg::STG_ABORTED) begin
          stage_d      = tftp_rx_pkg::STG_COMPLETED;
          act_d        = tftp_rx_pkg::ACT_FINISH;
          res_d.status = tftp_rx_pkg::STS_USER_ABORT;
        end else if (live) begin
          if (server_known_q && (server_q != ev_q.src_tid)) begin
            // frame from a stranger counts against the retry budget
            retries_d = retries_inc;
            if (retry_gone) begin
              stage_d      = tftp_rx_pkg::STG_COMPLETED;
              act_d        = tftp_rx_pkg::ACT_FINISH;
              res_d.status = tftp_rx_pkg::STS_BAD_SERVER;
            end else begin
              act_d = tftp_rx_pkg::ACT_RECEIVE;
            end
          end else begin
            // first frame latches the server transfer id
            if (!server_known_q) begin
              server_d       = ev_q.src_tid;
              server_known_d = 1'b1;
            end
            if (!ev_q.frame_ok) begin
              act_d = tftp_rx_pkg::ACT_RECEIVE;
            end else if (ev_q.opcode != tftp_rx_pkg::OpcData) begin
              stage_d             = tftp_rx_pkg::STG_COMPLETED;
              act_d               = tftp_rx_pkg::ACT_FINISH;
              res_d.status        = tftp_rx_pkg::STS_REMOTE_ERR;
              res_d.status_detail = ev_q.remote_error;
            end else if (ev_q.blk_num != next_blk) begin
              // out of order block, ack it and keep state
              act_d           = tftp_rx_pkg::ACT_ACK;
              res_d.ack_block = ev_q.blk_num;
            end else begin
              last_blk_d       = ev_q.blk_num;
              res_d.store_data = 1'b1;
              if (!ev_q.sink_ok) begin
                stage_d      = tftp_rx_pkg::STG_COMPLETED;
                act_d        = tftp_rx_pkg::ACT_FINISH;
                res_d.status = tftp_rx_pkg::STS_SINK_ERR;
              end else begin
                retries_d       = '0;
                act_d           = tftp_rx_pkg::ACT_ACK;
                res_d.ack_block = ev_q.blk_num;
                if (short_blk) begin
                  final_d = 1'b1;
                end
              end
            end
          end
        end
      end
      tftp_rx_pkg::OP_SENT: begin
        if (live) begin
          if (final_q) begin
            stage_d      = tftp_rx_pkg::STG_COMPLETED;
            act_d        = tftp_rx_pkg::ACT_FINISH;
            res_d.status = tftp_rx_pkg::STS_SUCCESS;
          end else begin
            act_d = tftp_rx_pkg::ACT_RECEIVE;
          end
        end
      end
      tftp_rx_pkg::OP_SEND_ERR: begin
        if (live) begin
          stage_d             = tftp_rx_pkg::STG_COMPLETED;
          act_d               = tftp_rx_pkg::ACT_FINISH;
          res_d.status        = tftp_rx_pkg::STS_SEND_ERR;
          res_d.status_detail = ev_q.link_error;
        end
      end
      tftp_rx_pkg::OP_ABORT: begin
        if (stage_q == tftp_rx_pkg::STG_RUNNING) begin
          stage_d = tftp_rx_pkg::STG_ABORTED;
        end
      end
      default: begin
        // unused event codes are ignored
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q        <= tftp_rx_pkg::STG_CONSTRUCTED;
      last_blk_q     <= '0;
      retries_q      <= '0;
      server_q       <= '0;
      server_known_q <= 1'b0;
      final_q        <= 1'b0;
    end else if (advance) begin
      stage_q        <= stage_d;
      last_blk_q     <= last_blk_d;
      retries_q      <= retries_d;
      server_q       <= server_d;
      server_known_q <= server_known_d;
      final_q        <= final_d;
    end
  end

  // result register, payload only
  tftp_rx_pkg::act_e    act_q;
  tftp_rx_pkg::result_t res_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      act_q <= act_d;
      res_q <= res_d;
    end
  end

  assign m_axis_tuser = act_q;
  assign m_axis_tdata = {{(tftp_rx_pkg::OutDataW - ResW){1'b0}}, res_q};

`ifndef ASSERT_OFF
  // a finish beat always leaves the transfer completed
  a_finish_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (act_d == tftp_rx_pkg::ACT_FINISH) |=>
      stage_q == tftp_rx_pkg::STG_COMPLETED)
    else $error("finish without completed stage");

  // completed is terminal
  a_completed_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q == tftp_rx_pkg::STG_COMPLETED |=> stage_q == tftp_rx_pkg::STG_COMPLETED)
    else $error("left completed stage");

  // status only reported with a finish
  a_status_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status != tftp_rx_pkg::STS_RUNNING) |->
      act_q == tftp_rx_pkg::ACT_FINISH)
    else $error("status on non-finish beat");

  // payload goes to the sink only with an ack or a sink error
  a_store_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.store_data |->
      (act_q == tftp_rx_pkg::ACT_ACK) ||
      (res_q.status == tftp_rx_pkg::STS_SINK_ERR))
    else $error("store flag on wrong action");
`endif

endmodule
